>>> hdl/rans_byte_encoder_assert.svh
// ---------------------------------------------------------------------------
// rANS byte encoder assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef RANS_BYTE_ENCODER_ASSERT_SVH
`define RANS_BYTE_ENCODER_ASSERT_SVH

// same-cycle implication
`define RBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbe: same-cycle check failed");

// next-cycle implication
`define RBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbe: next-cycle check failed");

`endif

>>> hdl/rbe_pkg.sv
// ---------------------------------------------------------------------------
// rbe_pkg
// Types, codes and default constants for the rANS byte encoder.
// ---------------------------------------------------------------------------
package rbe_pkg;

  localparam int TABLE_LOG_DEF = 12;
  localparam int LOWER_LOG_DEF = 31;
  localparam int SYMBOLS_DEF   = 256;

  localparam int FREQ_W = 16;
  localparam int CUM_W  = 17;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ZERO_FREQ = 2'd1,
    ERR_RANGE     = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hdl/rans_byte_encoder.sv
// ---------------------------------------------------------------------------
// rans_byte_encoder
// rANS entropy encoder, 64-bit state, byte renormalisation.
// ---------------------------------------------------------------------------
// Load words give no output. An encode word holds the input through the
// accept, a table read, one renormalisation step per output byte (up to 7),
// the bit-serial divider and the add states S_ADD_R and S_ADD_C. After that
// comes one output word per cycle while out_stall is low. A finish word gives
// 8 state bytes, one per cycle while out_stall is low. Errors give a word with
// out_byte 0; an overflow found after renormalisation bytes gives those bytes
// first. Input is taken only between words; the last output word may still
// wait in the output register while the next input word is accepted.
// ---------------------------------------------------------------------------
module rans_byte_encoder #(
  parameter int TABLE_LOG = rbe_pkg::TABLE_LOG_DEF,
  parameter int LOWER_LOG = rbe_pkg::LOWER_LOG_DEF,
  parameter int SYMBOLS   = rbe_pkg::SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  symbol,
  input  logic [15:0] frequency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic [1:0]  error,
  output logic [31:0] block_bytes
);
  import rbe_pkg::*;

  localparam int IDXW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SH   = LOWER_LOG - TABLE_LOG + 8;
  localparam logic [63:0] LBOUND = 64'd1 << LOWER_LOG;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOKUP = 8'b0000_0010,
    S_RENORM = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_ADD_R  = 8'b0001_0000,
    S_ADD_C  = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t            st;
  logic [63:0]       x;
  logic [63:0]       xs;
  logic [63:0]       ex;
  logic [31:0]       byte_count;
  logic [CUM_W-1:0]  running_sum;
  logic [FREQ_W-1:0] fr;
  logic [CUM_W-1:0]  cum;
  logic              sym_ok;
  logic [3:0]        n;
  logic [3:0]        cnt;
  err_t              err;
  logic              fin;
  logic [31:0]       size;
  logic [64:0]       vr;
  logic              ovf;

  logic              acc;
  logic              in_range;
  logic              tbl_we;
  logic              tbl_re;
  entry_t            tbl_wdata;
  entry_t            tbl_rdata;
  logic              div_start;
  div_status_t       div_st;
  logic [63:0]       quot;
  logic [FREQ_W-1:0] rem;
  logic              renorm_go;
  logic [64:0]       sum_c;
  logic              out_free;
  logic              out_load;

  assign in_stall  = (st != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign in_range  = (x >= LBOUND) && ((x >> LOWER_LOG) < 64'd256);
  assign tbl_we    = acc && (mode_t'(mode) == MODE_LOAD) && (32'(symbol) < SYMBOLS);
  assign tbl_re    = acc && (mode_t'(mode) == MODE_ENCODE);
  assign tbl_wdata = '{freq: frequency, cum: running_sum};
  assign renorm_go = ((xs >> SH) >= {48'd0, fr}) && (n < 4'd7);
  assign div_start = (st == S_RENORM) && !renorm_go;
  assign sum_c     = {1'b0, vr[63:0]} + {48'd0, cum};
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (st == S_EMIT) && out_free;

  rbe_table #(.SYMBOLS(SYMBOLS), .IDXW(IDXW)) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (symbol[IDXW-1:0]),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (symbol[IDXW-1:0]),
    .rdata (tbl_rdata)
  );

  rbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (xs),
    .divisor  (fr),
    .status   (div_st),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      x           <= LBOUND;
      byte_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
      err         <= ERR_NONE;
      fin         <= 1'b0;
      n           <= '0;
      cnt         <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (acc) begin
            cnt    <= '0;
            xs     <= x;
            ex     <= x;
            sym_ok <= (32'(symbol) < SYMBOLS);
            unique case (mode_t'(mode))
              MODE_LOAD: begin
                if (32'(symbol) < SYMBOLS) begin
                  running_sum <= running_sum + CUM_W'(frequency);
                end
              end
              MODE_ENCODE: begin
                n   <= '0;
                fin <= 1'b0;
                if (!in_range) begin
                  err        <= ERR_RANGE;
                  x          <= LBOUND;
                  byte_count <= '0;
                  st         <= S_EMIT;
                end else begin
                  err <= ERR_NONE;
                  st  <= S_LOOKUP;
                end
              end
              MODE_FINISH: begin
                x          <= LBOUND;
                byte_count <= '0;
                st         <= S_EMIT;
                if (!in_range) begin
                  err <= ERR_RANGE;
                  n   <= '0;
                  fin <= 1'b0;
                end else if (byte_count > 32'hFFFF_FFF7) begin
                  err <= ERR_OVERFLOW;
                  n   <= '0;
                  fin <= 1'b0;
                end else begin
                  err         <= ERR_NONE;
                  running_sum <= '0;
                  n           <= 4'd8;
                  fin         <= 1'b1;
                  size        <= byte_count + 32'd8;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOOKUP: begin
          fr  <= sym_ok ? tbl_rdata.freq : '0;
          cum <= tbl_rdata.cum;
          if (!sym_ok || (tbl_rdata.freq == '0)) begin
            err        <= ERR_ZERO_FREQ;
            x          <= LBOUND;
            byte_count <= '0;
            st         <= S_EMIT;
          end else begin
            st <= S_RENORM;
          end
        end
        S_RENORM: begin
          if (renorm_go) begin
            if (byte_count == 32'hFFFF_FFFF) begin
              err        <= ERR_OVERFLOW;
              x          <= LBOUND;
              byte_count <= '0;
              st         <= S_EMIT;
            end else begin
              n          <= n + 4'd1;
              byte_count <= byte_count + 32'd1;
              xs         <= xs >> 8;
            end
          end else begin
            st <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            ovf <= ((quot >> (64 - TABLE_LOG)) != 64'd0);
            vr  <= {1'b0, quot << TABLE_LOG} + {49'd0, rem};
            st  <= S_ADD_R;
          end
        end
        S_ADD_R: begin
          ovf <= ovf | vr[64];
          st  <= S_ADD_C;
        end
        S_ADD_C: begin
          if (ovf || sum_c[64]) begin
            err        <= ERR_OVERFLOW;
            x          <= LBOUND;
            byte_count <= '0;
            st         <= S_EMIT;
          end else begin
            x  <= sum_c[63:0];
            st <= (n == 4'd0) ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (cnt < n) begin
              out_byte    <= ex[7:0];
              last        <= (cnt == n - 4'd1) && (err == ERR_NONE);
              error       <= ERR_NONE;
              block_bytes <= fin ? size : 32'd0;
              ex          <= ex >> 8;
              cnt         <= cnt + 4'd1;
              if ((cnt == n - 4'd1) && (err == ERR_NONE)) begin
                st <= S_IDLE;
              end
            end else begin
              out_byte    <= '0;
              last        <= 1'b1;
              error       <= err;
              block_bytes <= '0;
              st          <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/rbe_table.sv
// ---------------------------------------------------------------------------
// rbe_table
// Frequency and cumulative table: one synchronous memory, registered read,
// per-entry valid bits so that unloaded entries read as zero after reset.
// ---------------------------------------------------------------------------
module rbe_table #(
  parameter int SYMBOLS = rbe_pkg::SYMBOLS_DEF,
  parameter int IDXW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [IDXW-1:0]   waddr,
  input  rbe_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [IDXW-1:0]   raddr,
  output rbe_pkg::entry_t   rdata
);
  import rbe_pkg::*;

  entry_t             mem [SYMBOLS];
  logic [SYMBOLS-1:0] vld;
  entry_t             rd_q;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

>>> hdl/rbe_div.sv
// ---------------------------------------------------------------------------
// rbe_div
// Restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module rbe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [rbe_pkg::FREQ_W-1:0]  divisor,
  output rbe_pkg::div_status_t        status,
  output logic [63:0]                 quot,
  output logic [rbe_pkg::FREQ_W-1:0]  rem
);
  import rbe_pkg::*;

  localparam int DW = 64;
  localparam int CW = $clog2(DW);

  logic [DW-1:0]     num;
  logic [FREQ_W-1:0] d;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;

  assign trial = {rem, num[DW-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      d    <= divisor;
      quot <= '0;
      rem  <= '0;
    end else if (busy) begin
      num <= {num[DW-2:0], 1'b0};
      if (!diff[FREQ_W]) begin
        rem  <= diff[FREQ_W-1:0];
        quot <= {quot[DW-2:0], 1'b1};
      end else begin
        rem  <= trial[FREQ_W-1:0];
        quot <= {quot[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

>>> hdl/rbe_checker.sv
// ---------------------------------------------------------------------------
// rbe_checker
// Port-level checks for the rANS byte encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "rans_byte_encoder_assert.svh"

module rbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last,
  input logic [1:0]  error,
  input logic [31:0] block_bytes
);
  import rbe_pkg::*;

  `RBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `RBE_ASSERT_NOW(a_err_word, out_valid && (error != ERR_NONE), (out_byte == 8'd0) && last)
  `RBE_ASSERT_NOW(a_size_clean, out_valid && (block_bytes != 32'd0), error == ERR_NONE)
  `RBE_ASSERT_NEXT(a_burst, out_valid && !out_stall && !last, out_valid)
  `RBE_ASSERT_NOW(a_burst_busy, out_valid && !last, in_stall)

endmodule

bind rans_byte_encoder rbe_checker u_rbe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .last        (last),
  .error       (error),
  .block_bytes (block_bytes)
);
